/* rtl/core/rof_pkg.sv */
// Shared types and constants for the 2-D rank-order filter.
// No dependencies; imported by every module of the block except rof_ram.
`timescale 1ns / 1ps

package rof_pkg;

  localparam int KSIZE_DEF     = 3;
  localparam int MAX_WIDTH_DEF = 1024;

  localparam int PIX_W     = 8;
  localparam int ROW_W     = 12;
  localparam int COL_W     = 10;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int M_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANK_INDEX   = 2'd2;

  localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;
  localparam logic [3:0]  RANK_INDEX_RST   = 4'd4;

  localparam logic [12:0] MAX_HEIGHT = 13'd4096;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } rof_meta_t;

  typedef struct packed {
    logic [10:0] image_width;
    logic [12:0] image_height;
  } rof_cfg_t;

endpackage

/* rtl/core/rank_order_filter_2d_top.sv */
// Pipeline from pixel accept to result: line RAM read, window shift, KSIZE*KSIZE-1 insertion
// cells, one output register. Throughput: one pixel per cycle; a held result stalls
// the whole chain. Reset (rst, synchronous): counters, valid bits and the
// configuration return to defaults; the line store is not cleared.
// Top level; depends on rof_pkg, rof_front, rof_sort_cell.
`timescale 1ns / 1ps

module rank_order_filter_2d_top #(
  parameter int KSIZE     = rof_pkg::KSIZE_DEF,
  parameter int MAX_WIDTH = rof_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] pixel
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rof_pkg::M_DATA_W-1:0]    m_tdata,   // [7:0] filtered, [19:8] centre_row,
                                                     // [29:20] centre_col, [31:30] zero
  output logic                            m_tlast,   // frame_end
  input  logic                            cfg_en,
  input  logic [rof_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rof_pkg::CFG_W-1:0]       cfg_data
);

  import rof_pkg::*;

  localparam int WIN_N = KSIZE * KSIZE;
  localparam int RW    = $clog2(WIN_N);

  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [3:0]  rank_index;
  rof_cfg_t    cfg;
  logic        advance;
  logic [RW-1:0] rank_eff;

  logic [WIN_N-1:0]                       stg_valid;
  logic [WIN_N-1:0][WIN_N-1:0][PIX_W-1:0] stg_data;
  rof_meta_t                              stg_meta [WIN_N];

  logic             out_valid;
  logic [PIX_W-1:0] out_pix;
  rof_meta_t        out_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
      rank_index   <= RANK_INDEX_RST;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[10:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        REG_RANK_INDEX:   rank_index   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg.image_width  = image_width;
  assign cfg.image_height = image_height;

  assign advance  = !out_valid || m_tready;
  assign s_tready = advance;

  rof_front #(
    .KSIZE     (KSIZE),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (s_tvalid),
    .pixel     (s_tdata),
    .cfg       (cfg),
    .out_valid (stg_valid[0]),
    .window    (stg_data[0]),
    .out_meta  (stg_meta[0])
  );

  for (genvar s = 1; s < WIN_N; s++) begin : g_cell
    rof_sort_cell #(
      .WIN_N (WIN_N),
      .IDX   (s)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .in_valid  (stg_valid[s-1]),
      .in_data   (stg_data[s-1]),
      .in_meta   (stg_meta[s-1]),
      .out_valid (stg_valid[s]),
      .out_data  (stg_data[s]),
      .out_meta  (stg_meta[s])
    );
  end

  assign rank_eff = (int'(rank_index) > WIN_N - 1) ? RW'(WIN_N - 1) : RW'(rank_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stg_valid[WIN_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pix  <= stg_data[WIN_N-1][rank_eff];
      out_meta <= stg_meta[WIN_N-1];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_meta.col, out_meta.row, out_pix};
  assign m_tlast  = out_meta.last;

endmodule

/* rtl/core/rof_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module rof_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/rof_front.sv */
// Front end: raster counters, line store (one RAM row per column), window registers.
// Depends on rof_pkg and rof_ram.
`timescale 1ns / 1ps

module rof_front #(
  parameter int KSIZE     = 3,
  parameter int MAX_WIDTH = 1024,
  localparam int WIN_N = KSIZE * KSIZE
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   advance,
  input  logic                                   in_valid,
  input  logic [rof_pkg::PIX_W-1:0]              pixel,
  input  rof_pkg::rof_cfg_t                      cfg,
  output logic                                   out_valid,
  output logic [WIN_N-1:0][rof_pkg::PIX_W-1:0]   window,
  output rof_pkg::rof_meta_t                     out_meta
);

  import rof_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int LB   = KSIZE - 1;
  localparam int HALF = KSIZE / 2;

  logic [CW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;
  logic [CW:0]      w_eff;
  logic [12:0]      h_eff;
  logic [CW:0]      col_inc;
  logic [12:0]      row_inc;
  logic             col_wrap;
  logic             row_wrap;
  logic             has_res;
  logic             accept;

  logic             a_valid;
  logic [PIX_W-1:0] a_pixel;
  logic [CW-1:0]    a_cs;
  logic             a_res;
  rof_meta_t        a_meta;

  logic                         fwd_hit;
  logic [LB-1:0][PIX_W-1:0]     fwd_data;
  logic [LB-1:0][PIX_W-1:0]     lines_rd;
  logic [LB-1:0][PIX_W-1:0]     lines_q;
  logic [LB-1:0][PIX_W-1:0]     lines_wr;
  logic [KSIZE-1:0][PIX_W-1:0]  column;

  assign w_eff = (int'(cfg.image_width) > MAX_WIDTH) ? (CW+1)'(MAX_WIDTH)
                                                     : (CW+1)'(cfg.image_width);
  assign h_eff = (cfg.image_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg.image_height;

  assign col_inc  = {1'b0, col_count} + (CW+1)'(1);
  assign row_inc  = {1'b0, row_count} + 13'd1;
  assign col_wrap = col_inc >= w_eff;
  assign row_wrap = row_inc >= h_eff;
  assign has_res  = (row_count >= ROW_W'(KSIZE - 1)) && (col_count >= CW'(KSIZE - 1)) &&
                    ({1'b0, row_count} < h_eff) && ({1'b0, col_count} < w_eff);
  assign accept   = advance && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_count <= '0;
        row_count <= row_wrap ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_count <= col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_pixel     <= pixel;
      a_cs        <= col_count;
      a_res       <= has_res;
      a_meta.row  <= row_count - ROW_W'(HALF);
      a_meta.col  <= COL_W'(col_count - CW'(HALF));
      a_meta.last <= col_wrap && row_wrap;
    end
  end

  rof_ram #(
    .WIDTH (LB * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (advance && a_valid),
    .wr_addr (a_cs),
    .wr_data (lines_wr),
    .rd_en   (advance),
    .rd_addr (col_count),
    .rd_data (lines_rd)
  );

  // read and write of the same column in one cycle: take the data being written
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (advance) begin
      fwd_hit <= a_valid && accept && (a_cs == col_count);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fwd_data <= lines_wr;
    end
  end

  assign lines_q = fwd_hit ? fwd_data : lines_rd;

  always_comb begin
    for (int a = 0; a < LB; a++) begin
      column[a] = lines_q[a];
    end
    column[KSIZE-1] = a_pixel;
    for (int a = 0; a < LB; a++) begin
      lines_wr[a] = column[a+1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance && a_valid) begin
      for (int a = 0; a < KSIZE; a++) begin
        for (int b = 0; b < KSIZE - 1; b++) begin
          window[a*KSIZE+b] <= window[a*KSIZE+b+1];
        end
        window[a*KSIZE+KSIZE-1] <= column[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= a_valid && a_res;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_meta <= a_meta;
    end
  end

endmodule

/* rtl/core/rof_sort_cell.sv */
// One insertion cell of the sort chain: inserts element IDX into the sorted prefix.
// Depends on rof_pkg.
`timescale 1ns / 1ps

module rof_sort_cell #(
  parameter int WIN_N = 9,
  parameter int IDX   = 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  advance,
  input  logic                                  in_valid,
  input  logic [WIN_N-1:0][rof_pkg::PIX_W-1:0]  in_data,
  input  rof_pkg::rof_meta_t                    in_meta,
  output logic                                  out_valid,
  output logic [WIN_N-1:0][rof_pkg::PIX_W-1:0]  out_data,
  output rof_pkg::rof_meta_t                    out_meta
);

  import rof_pkg::*;

  logic [PIX_W-1:0]             x;
  logic [WIN_N-1:0][PIX_W-1:0]  ins;

  always_comb begin
    x   = in_data[IDX];
    ins = in_data;
    ins[0] = (in_data[0] <= x) ? in_data[0] : x;
    for (int p = 1; p <= IDX; p++) begin
      if (p == IDX) begin
        ins[p] = (in_data[p-1] > x) ? in_data[p-1] : x;
      end else if (in_data[p] <= x) begin
        ins[p] = in_data[p];
      end else begin
        ins[p] = (in_data[p-1] > x) ? in_data[p-1] : x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= ins;
      out_meta <= in_meta;
    end
  end

endmodule

/* rtl/core/rof_checker.sv */
// Port-level checks for the rank-order filter top level, attached by bind.
// Depends on rank_order_filter_2d_top and rof_pkg.
`timescale 1ns / 1ps

module rof_checker #(
  parameter int KSIZE = rof_pkg::KSIZE_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rof_pkg::M_DATA_W-1:0]  m_tdata,
  input logic                          m_tlast
);

  import rof_pkg::*;

  localparam int HALF = KSIZE / 2;

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // input is taken exactly when the output register can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // centre row of an interior window is never above the border; padding bits are zero
  a_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[19:8] >= ROW_W'(HALF)) && (m_tdata[31:30] == 2'b00))
    else $error("centre row inside border or padding set");

endmodule

bind rank_order_filter_2d_top rof_checker #(.KSIZE(KSIZE)) u_rof_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

/* verif/rank_filter_checker.sv */
// Result checker for the 2-D rank-order filter: watches the config port and both
// streams, predicts every filtered pixel and compares it with the DUT output.
// Depends on rof_pkg.
`timescale 1ns / 1ps

module rank_filter_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] pixel
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [rof_pkg::M_DATA_W-1:0]  m_tdata,   // [7:0] filtered, [19:8] centre_row,
                                                   // [29:20] centre_col, [31:30] zero
  input  logic                          m_tlast,   // frame_end
  input  logic                          cfg_en,
  input  logic [rof_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rof_pkg::CFG_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            outstanding,
  output int                            results_checked
);

  import rof_pkg::*;

  localparam int WIN = KSIZE_DEF * KSIZE_DEF;

  typedef struct packed {
    logic [PIX_W-1:0] filtered;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             frame_end;
  } ranked_pixel_t;

  logic [10:0] width_reg;
  logic [12:0] height_reg;
  logic [3:0]  rank_reg;

  logic [7:0]  line_mem [KSIZE_DEF-1][MAX_WIDTH_DEF];
  logic [7:0]  win [WIN];
  int unsigned row_pos;
  int unsigned col_pos;

  ranked_pixel_t expected_px_q[$];
  int fail_total   = 0;
  int result_total = 0;

  function automatic logic [7:0] rank_select(input logic [3:0] rank);
    logic [7:0]  v [WIN];
    logic [7:0]  t;
    int unsigned r;
    v = win;
    for (int i = 0; i < WIN - 1; i++) begin
      for (int j = 0; j < WIN - 1 - i; j++) begin
        if (v[j] > v[j+1]) begin
          t      = v[j];
          v[j]   = v[j+1];
          v[j+1] = t;
        end
      end
    end
    r = (rank > WIN - 1) ? WIN - 1 : rank;
    return v[r];
  endfunction

  task automatic absorb_pixel(input logic [7:0] px);
    logic [7:0]    column [KSIZE_DEF];
    int unsigned   w;
    int unsigned   h;
    int unsigned   cs;
    ranked_pixel_t res;
    w  = (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
    h  = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    cs = col_pos % MAX_WIDTH_DEF;
    for (int a = 0; a < KSIZE_DEF - 1; a++) column[a] = line_mem[a][cs];
    column[KSIZE_DEF-1] = px;
    for (int a = 0; a < KSIZE_DEF; a++) begin
      for (int b = 0; b < KSIZE_DEF - 1; b++)
        win[a*KSIZE_DEF+b] = win[a*KSIZE_DEF+b+1];
      win[a*KSIZE_DEF+KSIZE_DEF-1] = column[a];
    end
    for (int a = 0; a < KSIZE_DEF - 1; a++) line_mem[a][cs] = column[a+1];

    if (row_pos >= KSIZE_DEF - 1 && col_pos >= KSIZE_DEF - 1 && row_pos < h && col_pos < w) begin
      res.filtered  = rank_select(rank_reg);
      res.row       = ROW_W'(row_pos - KSIZE_DEF / 2);
      res.col       = COL_W'(col_pos - KSIZE_DEF / 2);
      res.frame_end = (col_pos + 1 >= w) && (row_pos + 1 >= h);
      expected_px_q.push_back(res);
    end

    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    ranked_pixel_t want;
    if (rst) begin
      width_reg  = IMAGE_WIDTH_RST;
      height_reg = IMAGE_HEIGHT_RST;
      rank_reg   = RANK_INDEX_RST;
      foreach (win[i]) win[i] = '0;
      foreach (line_mem[a, b]) line_mem[a][b] = '0;
      row_pos = 0;
      col_pos = 0;
      expected_px_q.delete();
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_reg  = cfg_data[10:0];
          REG_IMAGE_HEIGHT: height_reg = cfg_data[12:0];
          REG_RANK_INDEX:   rank_reg   = cfg_data[3:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) absorb_pixel(s_tdata);
      if (m_tvalid && m_tready) begin
        result_total++;
        if (expected_px_q.size() == 0) begin
          $error("unexpected result: filtered %0d row %0d col %0d last %0b",
                 m_tdata[7:0], m_tdata[19:8], m_tdata[29:20], m_tlast);
          fail_total++;
        end else begin
          want = expected_px_q.pop_front();
          compare_field("filtered", want.filtered, m_tdata[7:0]);
          compare_field("centre_row", want.row, m_tdata[19:8]);
          compare_field("centre_col", want.col, m_tdata[29:20]);
          compare_field("frame_end", want.frame_end, m_tlast);
        end
      end
    end
    mismatches      <= fail_total;
    outstanding     <= expected_px_q.size();
    results_checked <= result_total;
  end

endmodule

/* verif/testbench.sv */
// Top of the rank-order filter testbench: clock, reset, frame stimulus, flow control
// and the verdict. Depends on rof_pkg, rank_order_filter_2d_top, rank_filter_checker.
`timescale 1ns / 1ps

module testbench;
  import rof_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 30;
  localparam int SMALL_TARGET = 700;
  localparam int LIST_LEN     = 27;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum {PAT_RANDOM, PAT_BINARY, PAT_NARROW, PAT_LIST} pix_pattern_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic [7:0]           s_tdata   = '0;
  logic                 m_tready  = 1'b0;
  logic                 cfg_en    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 s_tready;
  logic                 m_tvalid;
  logic [M_DATA_W-1:0]  m_tdata;
  logic                 m_tlast;

  int mismatches;
  int outstanding;
  int results_checked;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int cycle_count   = 0;
  int pixels_sent   = 0;
  int frames_sent   = 0;
  int list_pos      = 0;

  // extremes first, then duplicates and mid values
  logic [7:0] corner_px [LIST_LEN] = '{
    8'd0,   8'd255, 8'd1,   8'd254, 8'd128, 8'd127, 8'd2,   8'd253, 8'd64,
    8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255,
    8'd7,   8'd7,   8'd200, 8'd7,   8'd0,   8'd200, 8'd255, 8'd7,   8'd90
  };

  rank_order_filter_2d_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rank_filter_checker rank_check (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast),
    .cfg_en          (cfg_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
      $display("rank_order_filter_2d_top test failed");
      $finish;
    end
  end

  // output side: random stalls, plus a long hold-off on request
  initial begin
    int stall_left;
    int holds_seen;
    stall_left = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic push_pixel(input logic [7:0] px);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic settle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one whole frame; registers change only here, with the block drained
  task automatic run_frame(input logic [12:0] w, input logic [12:0] h,
                           input logic [3:0] rank, input idle_mode_t mode,
                           input pix_pattern_t pat);
    int unsigned ew;
    int unsigned eh;
    logic [7:0]  px;
    ew = (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : ((w == 0) ? 1 : w);
    eh = (h > MAX_HEIGHT) ? MAX_HEIGHT : ((h == 0) ? 1 : h);
    send_idle_pct = (mode == IDLE_SEND) ? 53 : ((mode == IDLE_BOTH) ? 10 : 0);
    recv_idle_pct = (mode == IDLE_RECV) ? 53 : ((mode == IDLE_BOTH) ? 10 : 0);
    cfg_en    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_RANK_INDEX;
    cfg_data  <= CFG_W'(rank);
    @(posedge clk);
    cfg_en <= 1'b0;
    for (int unsigned i = 0; i < ew * eh; i++) begin
      case (pat)
        PAT_BINARY: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        PAT_NARROW: px = 8'($urandom_range(0, 3));
        PAT_LIST: begin
          px = corner_px[list_pos % LIST_LEN];
          list_pos++;
        end
        default:    px = 8'($urandom_range(0, 255));
      endcase
      push_pixel(px);
    end
    s_tvalid <= 1'b0;
    frames_sent++;
    settle();
  endtask

  initial begin
    int unsigned  w;
    int unsigned  h;
    int unsigned  small_px;
    int           idx;
    logic [3:0]   rank;
    idle_mode_t   mode;
    pix_pattern_t pat;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // median, saturated rank, minimum on hand-picked 3x3 frames
    run_frame(3, 3, 4, IDLE_NONE, PAT_LIST);
    run_frame(3, 3, 15, IDLE_NONE, PAT_LIST);
    run_frame(3, 3, 0, IDLE_NONE, PAT_LIST);

    small_px = 0;
    idx      = 0;
    while (small_px < SMALL_TARGET || idx < 32) begin
      mode = idle_mode_t'(idx % 4);
      case ($urandom_range(0, 5))
        0:       pat = PAT_BINARY;
        1:       pat = PAT_NARROW;
        default: pat = PAT_RANDOM;
      endcase
      rank = (idx < 16) ? 4'(idx) : 4'($urandom_range(0, 15));
      case (idx)
        5: begin
          // one row wider than the line store
          w = 2047;
          h = 1;
        end
        25: begin
          w = 0;
          h = 5;
        end
        26: begin
          w = 2;
          h = 4;
        end
        27: begin
          w = 5;
          h = 0;
        end
        28: begin
          w = 4;
          h = 2;
        end
        29: begin
          w = 1;
          h = 1;
        end
        8, 30: begin
          // output held off while input keeps coming: pipeline must back up
          w    = 24;
          h    = 6;
          mode = IDLE_NONE;
          hold_requests++;
        end
        default: begin
          w = $urandom_range(3, 9);
          h = $urandom_range(3, 8);
          small_px += w * h;
        end
      endcase
      run_frame(13'(w), 13'(h), rank, mode, pat);
      idx++;
    end

    $display("Sent %0d pixels in %0d frames; %0d filtered results checked",
             pixels_sent, frames_sent, results_checked);
    $display("Covered ranks 0-15, sizes from empty frames to rows clipped at 1024, "
             , "four flow-control mixes and output hold-offs");
    if (mismatches == 0) begin
      $display("rank_order_filter_2d_top test passed");
    end else begin
      $display("rank_order_filter_2d_top test failed");
    end
    $finish;
  end

endmodule
